@@ hdl/rmmwf_pkg.sv @@
// shared types and constants for the rgb median/mean window filter
`default_nettype none
package rmmwf_pkg;

	localparam int SIDE      = 3;
	localparam int CELLS     = SIDE * SIDE;
	localparam int CHAN_W    = 8;
	localparam int IDX_W     = $clog2(CELLS);
	localparam int POS_W     = $clog2(CELLS);
	localparam int COL_W     = $clog2(SIDE);
	localparam int SUM_W     = 12;
	// divide by ten as multiply by 3277 / 2^15, exact for sums below 4096
	localparam int RECIP_W   = 12;
	localparam int RECIP_SH  = 15;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(3277);
	localparam int PROD_W    = SUM_W + RECIP_W;

	// center slot of the middle row when the window is freshly reloaded
	localparam logic [IDX_W-1:0] RELOAD_CENTER = IDX_W'((SIDE / 2) * SIDE + SIDE / 2);
	localparam logic [IDX_W-1:0] MID_ROW_BASE  = IDX_W'((SIDE / 2) * SIDE);

	typedef logic [CHAN_W-1:0] pix_t;
	typedef pix_t [CELLS-1:0] win_t;

	// group status from the window store
	typedef struct packed {
		logic              done;
		logic [IDX_W-1:0]  center;
	} grp_t;

	// per-stage load enables for the lanes
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} lane_en_t;

endpackage
`default_nettype wire

@@ hdl/rmmwf_if.sv @@
// valid/ready channel interfaces for pixel and result beats
`default_nettype none
interface rmmwf_pix_if;
	logic       valid;
	logic       ready;
	logic       new_window;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, new_window, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, new_window, red_in, green_in, blue_in, output ready);
endinterface

interface rmmwf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

@@ hdl/rgb_median_mean_window_filter_top.sv @@
// top level: window store, three channel lanes and output register
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------
//   pix     | in  | new_window, red_in, green_in, blue_in
//   res     | out | red_out, green_out, blue_out
//
// one pixel beat is taken per cycle while pix.ready is high; the beat
// completing a group (nine-pixel reload or three-pixel column) passes
// through the lane pipeline: snapshot, sort, merge, blend, multiply,
// output register, and res.valid rises once it reaches the output register.
// each stage holds when the next one is full,
// so pix.ready drops only when the snapshot stage cannot move on.
// reset clears group position, kind, column rotation and all valid bits.
`default_nettype none
module rgb_median_mean_window_filter_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rmmwf_pix_if.sink  pix,
	rmmwf_res_if.source res
);
	import rmmwf_pkg::*;

	localparam int LANES = 3;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, vo_q;
	logic ld1, ld_out;
	lane_en_t en;

	win_t             red_snap, green_snap, blue_snap;
	grp_t             grp;
	win_t [LANES-1:0] win_s1;
	logic [IDX_W-1:0] center_s1;
	pix_t [LANES-1:0] lane_res;
	pix_t [LANES-1:0] out_q;

	logic take;

	// stage advance, back to front
	always_comb begin
		ld_out   = v5_s5 && (!vo_q || res.ready);
		en.ld_s5 = v4_s4 && (!v5_s5 || ld_out);
		en.ld_s4 = v3_s3 && (!v4_s4 || en.ld_s5);
		en.ld_s3 = v2_s2 && (!v3_s3 || en.ld_s4);
		en.ld_s2 = v1_s1 && (!v2_s2 || en.ld_s3);
	end

	assign pix.ready = !v1_s1 || en.ld_s2;
	assign take      = pix.valid && pix.ready;
	assign ld1       = take && grp.done;

	rmmwf_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.new_window (pix.new_window),
		.red        (pix.red_in),
		.green      (pix.green_in),
		.blue       (pix.blue_in),
		.red_snap   (red_snap),
		.green_snap (green_snap),
		.blue_snap  (blue_snap),
		.grp        (grp)
	);

	// s1: window snapshot at group end
	always_ff @(posedge clk) begin
		if (ld1) begin
			win_s1[0] <= red_snap;
			win_s1[1] <= green_snap;
			win_s1[2] <= blue_snap;
			center_s1 <= grp.center;
		end
	end

	// channel lanes
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		rmmwf_lane u_lane (
			.clk    (clk),
			.en     (en),
			.win    (win_s1[l]),
			.center (center_s1),
			.result (lane_res[l])
		);
	end

	// output register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q <= lane_res;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			vo_q  <= 1'b0;
		end else begin
			v1_s1 <= ld1 || (v1_s1 && !en.ld_s2);
			v2_s2 <= en.ld_s2 || (v2_s2 && !en.ld_s3);
			v3_s3 <= en.ld_s3 || (v3_s3 && !en.ld_s4);
			v4_s4 <= en.ld_s4 || (v4_s4 && !en.ld_s5);
			v5_s5 <= en.ld_s5 || (v5_s5 && !ld_out);
			vo_q  <= ld_out || (vo_q && !res.ready);
		end
	end

	assign res.valid     = vo_q;
	assign res.red_out   = out_q[0];
	assign res.green_out = out_q[1];
	assign res.blue_out  = out_q[2];

	// a completing beat always lands in the snapshot stage
	a_group_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld1 |=> v1_s1)
		else $error("group end beat not captured");

	// a held snapshot blocks the pixel input
	a_s1_block: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && !en.ld_s2 |-> !pix.ready)
		else $error("pixel taken while snapshot stage is stuck");

	// a finished product is not dropped while the output waits
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v5_s5 && vo_q && !res.ready |=> v5_s5)
		else $error("multiply stage lost a result");

	// only the last stage feeds the output register
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> v5_s5 && !(vo_q && !res.ready))
		else $error("output loaded without a ready source");

endmodule
`default_nettype wire

@@ hdl/rmmwf_window.sv @@
// window store: group tracking, slot writes and window snapshot
`default_nettype none
module rmmwf_window (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic                new_window,
	input  wire rmmwf_pkg::pix_t     red,
	input  wire rmmwf_pkg::pix_t     green,
	input  wire rmmwf_pkg::pix_t     blue,
	output rmmwf_pkg::win_t          red_snap,
	output rmmwf_pkg::win_t          green_snap,
	output rmmwf_pkg::win_t          blue_snap,
	output rmmwf_pkg::grp_t          grp
);
	import rmmwf_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             reload_q;
	logic [COL_W-1:0] oldest_q;
	win_t             red_q, green_q, blue_q;

	logic             reload_now;
	logic [IDX_W-1:0] slot;
	logic             last;
	logic [COL_W-1:0] oldest_next;

	// group kind, target slot and end of group
	always_comb begin
		reload_now = (pos_q == '0) ? new_window : reload_q;
		if (reload_now) begin
			slot = IDX_W'(pos_q);
			last = (pos_q == POS_W'(CELLS - 1));
		end else begin
			slot = IDX_W'(pos_q * POS_W'(SIDE)) + IDX_W'(oldest_q);
			last = (pos_q == POS_W'(SIDE - 1));
		end
		oldest_next = (oldest_q == COL_W'(SIDE - 1)) ? '0 : oldest_q + 1'b1;
	end

	// snapshot with this beat already written in
	always_comb begin
		red_snap         = red_q;
		green_snap       = green_q;
		blue_snap        = blue_q;
		red_snap[slot]   = red;
		green_snap[slot] = green;
		blue_snap[slot]  = blue;
	end

	// center of the window after this group, in physical slots
	always_comb begin
		grp.done = last;
		if (reload_now) begin
			grp.center = RELOAD_CENTER;
		end else begin
			// (oldest_next + 1) mod 3 equals (oldest + 2) mod 3
			grp.center = MID_ROW_BASE
				+ IDX_W'((oldest_q == '0) ? COL_W'(SIDE - 1) : oldest_q - 1'b1);
		end
	end

	// window payload
	always_ff @(posedge clk) begin
		if (take) begin
			red_q   <= red_snap;
			green_q <= green_snap;
			blue_q  <= blue_snap;
		end
	end

	// group counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			reload_q <= 1'b0;
			oldest_q <= '0;
		end else if (take) begin
			reload_q <= reload_now;
			if (last) begin
				pos_q    <= '0;
				oldest_q <= reload_now ? '0 : oldest_next;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/rmmwf_lane.sv @@
// one channel lane: median of nine, window sum, blend and divide by ten
`default_nettype none
module rmmwf_lane (
	input  wire logic                          clk,
	input  wire rmmwf_pkg::lane_en_t           en,
	input  wire rmmwf_pkg::win_t               win,
	input  wire logic [rmmwf_pkg::IDX_W-1:0]   center,
	output rmmwf_pkg::pix_t                    result
);
	import rmmwf_pkg::*;

	typedef pix_t [2:0] trio_t;

	function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
		pix_t lo, hi, t;
		trio_t r;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c < lo) begin
			t  = lo;
			lo = c;
			c  = t;
		end
		if (c > hi) begin
			t  = hi;
			hi = c;
			c  = t;
		end
		r[0] = lo;
		r[1] = c;
		r[2] = hi;
		return r;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		trio_t r;
		r = sort3(a, b, c);
		return r[0];
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		trio_t r;
		r = sort3(a, b, c);
		return r[1];
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		trio_t r;
		r = sort3(a, b, c);
		return r[2];
	endfunction

	trio_t [SIDE-1:0]  trio_s2;
	logic [SUM_W-1:0]  part_s2;
	pix_t              lo_s3, mi_s3, hi_s3;
	logic [SUM_W-1:0]  part_s3;
	logic [SUM_W-1:0]  val_s4;
	logic [PROD_W-1:0] prod_s5;

	logic [SUM_W-1:0]  sum9;

	// full window sum
	always_comb begin
		sum9 = '0;
		for (int i = 0; i < CELLS; i++) begin
			sum9 = sum9 + SUM_W'(win[i]);
		end
	end

	// s2: sort each group of three, partial sum
	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			for (int g = 0; g < SIDE; g++) begin
				trio_s2[g] <= sort3(win[g*SIDE], win[g*SIDE+1], win[g*SIDE+2]);
			end
			part_s2 <= sum9 - SUM_W'(win[center]);
		end
	end

	// s3: max of mins, median of mids, min of maxes
	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			lo_s3   <= max3(trio_s2[0][0], trio_s2[1][0], trio_s2[2][0]);
			mi_s3   <= med3(trio_s2[0][1], trio_s2[1][1], trio_s2[2][1]);
			hi_s3   <= min3(trio_s2[0][2], trio_s2[1][2], trio_s2[2][2]);
			part_s3 <= part_s2;
		end
	end

	// s4: add twice the median
	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			val_s4 <= part_s3 + SUM_W'({med3(lo_s3, mi_s3, hi_s3), 1'b0});
		end
	end

	// s5: reciprocal multiply for the divide by ten
	always_ff @(posedge clk) begin
		if (en.ld_s5) begin
			prod_s5 <= PROD_W'(val_s4) * PROD_W'(RECIP);
		end
	end

	assign result = prod_s5[RECIP_SH +: CHAN_W];

endmodule
`default_nettype wire
